FILE: hdl/s256_pkg.sv
`timescale 1ns / 1ps
package s256_pkg;

    typedef logic [31:0] t_word;
    typedef logic [0:7][31:0] t_hash;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [5:0] rnd;
    } t_rnd_ctrl;

    typedef struct packed {
        logic       shift;
        logic [7:0] din;
        logic       step;
    } t_sched_ctrl;

    localparam t_hash C_H0 = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word C_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] C_PAD_MARK = 8'h80;
    localparam logic [5:0] C_LEN_POS  = 6'd56;
    localparam logic [5:0] C_LAST_POS = 6'd63;
    localparam logic [5:0] C_LAST_RND = 6'd63;

    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

FILE: hdl/s256_sched.sv
`timescale 1ns / 1ps
module s256_sched (
    input  logic                   i_clk,
    input  s256_pkg::t_sched_ctrl  i_ctrl,
    output s256_pkg::t_word        o_w
);
    import s256_pkg::*;

    // window of 16 words, w[t] in the top bits; bytes enter at the bottom
    logic [511:0] r_win;
    t_word        w_new;

    function automatic t_word win_word(input logic [511:0] win, input int j);
        return win[511 - 32*j -: 32];
    endfunction

    always_comb begin
        w_new = small_sig1(win_word(r_win, 14)) + win_word(r_win, 9)
              + small_sig0(win_word(r_win, 1)) + win_word(r_win, 0);
    end

    assign o_w = win_word(r_win, 0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_win <= {r_win[503:0], i_ctrl.din};
        end else if (i_ctrl.step) begin
            r_win <= {r_win[479:0], w_new};
        end
    end

endmodule

FILE: hdl/s256_round.sv
`timescale 1ns / 1ps
module s256_round (
    input  logic                 i_clk,
    input  s256_pkg::t_rnd_ctrl  i_ctrl,
    input  s256_pkg::t_hash      i_hash,
    input  s256_pkg::t_word      i_w,
    output s256_pkg::t_hash      o_work
);
    import s256_pkg::*;

    t_hash r_work;
    t_word w_t1;
    t_word w_t2;
    t_word w_ch;
    t_word w_maj;

    always_comb begin
        w_ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
        w_maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
              ^ (r_work[1] & r_work[2]);
        w_t1  = r_work[7] + big_sig1(r_work[4]) + w_ch + C_K[i_ctrl.rnd] + i_w;
        w_t2  = big_sig0(r_work[0]) + w_maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_work <= i_hash;
        end else if (i_ctrl.step) begin
            r_work <= '{w_t1 + w_t2, r_work[0], r_work[1], r_work[2],
                        r_work[3] + w_t1, r_work[4], r_work[5], r_work[6]};
        end
    end

    assign o_work = r_work;

endmodule

FILE: hdl/sha256_message_hash.sv
`timescale 1ns / 1ps
// SHA-256 over a byte stream. The request that fills a 64-byte block keeps the
// input stalled while its 64 rounds run through the single shared round unit,
// one per cycle, and the result is folded into the hash. A request with tlast
// pads the message one byte per cycle up to the end of the block, compresses one
// or two more blocks and presents the digest in an output register, so the next
// message may start while the digest waits to be taken.
module sha256_message_hash (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // data_byte
    input  logic         i_s_axis_tuser,   // empty_req
    input  logic         i_s_axis_tlast,   // last
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [255:0] o_m_axis_tdata    // digest_part0, part1, part2, part3
);
    import s256_pkg::*;

    t_state       r_state;
    t_state       n_state;
    logic [60:0]  r_count;
    t_hash        r_hash;
    logic [5:0]   r_rnd;
    logic [5:0]   r_ppos;
    logic         r_fin;
    logic         r_mark;
    logic         r_lastblk;
    logic         r_done;
    logic         r_out_valid;
    logic [255:0] r_out_data;

    logic         w_s_acc;
    logic         w_out_free;
    logic         w_emit;
    logic [63:0]  w_bits;
    logic [63:0]  w_len_sh;
    logic [7:0]   w_pad_byte;
    logic [255:0] w_digest;
    t_sched_ctrl  w_sched_ctrl;
    t_rnd_ctrl    w_rnd_ctrl;
    t_word        w_w;
    t_hash        w_work;

    assign w_s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_bits     = {r_count, 3'b000};
    assign w_len_sh   = w_bits >> {~r_ppos[2:0], 3'b000};

    always_comb begin
        if (!r_mark) begin
            w_pad_byte = C_PAD_MARK;
        end else if (r_lastblk && r_ppos >= C_LEN_POS) begin
            w_pad_byte = w_len_sh[7:0];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_digest[64*i +: 64] = {r_hash[2*i], r_hash[2*i+1]};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    if (!i_s_axis_tuser && r_count[5:0] == C_LAST_POS) begin
                        n_state = S_ROUND;
                    end else if (i_s_axis_tlast) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_ppos == C_LAST_POS) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_rnd == C_LAST_RND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (r_done) begin
                    n_state = S_EMIT;
                end else if (r_fin) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready    = 1'b0;
        w_emit             = 1'b0;
        w_sched_ctrl.shift = 1'b0;
        w_sched_ctrl.din   = w_pad_byte;
        w_sched_ctrl.step  = 1'b0;
        w_rnd_ctrl.load    = (n_state == S_ROUND) && (r_state != S_ROUND);
        w_rnd_ctrl.step    = 1'b0;
        w_rnd_ctrl.rnd     = r_rnd;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready    = 1'b1;
                w_sched_ctrl.shift = w_s_acc && !i_s_axis_tuser;
                w_sched_ctrl.din   = i_s_axis_tdata;
            end
            S_PAD: begin
                w_sched_ctrl.shift = 1'b1;
            end
            S_ROUND: begin
                w_sched_ctrl.step = 1'b1;
                w_rnd_ctrl.step   = 1'b1;
            end
            S_FOLD: begin
            end
            S_EMIT: begin
                w_emit = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_hash      <= C_H0;
            r_rnd       <= '0;
            r_ppos      <= '0;
            r_fin       <= 1'b0;
            r_mark      <= 1'b0;
            r_lastblk   <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_IDLE && w_s_acc) begin
                r_fin     <= i_s_axis_tlast;
                r_mark    <= 1'b0;
                r_lastblk <= 1'b0;
                r_done    <= 1'b0;
                if (!i_s_axis_tuser) begin
                    r_count <= r_count + 61'd1;
                    r_ppos  <= r_count[5:0] + 6'd1;
                end else begin
                    r_ppos  <= r_count[5:0];
                end
            end

            if (r_state == S_PAD) begin
                r_ppos <= r_ppos + 6'd1;
                if (!r_mark) begin
                    r_mark <= 1'b1;
                end
                // block end: either the length went in, or it goes in the next block
                if (r_ppos == C_LAST_POS) begin
                    if (r_mark && r_lastblk) begin
                        r_done <= 1'b1;
                    end else begin
                        r_lastblk <= 1'b1;
                    end
                end else if (!r_mark) begin
                    r_lastblk <= (r_ppos < C_LEN_POS);
                end
            end

            if (r_state == S_ROUND) begin
                r_rnd <= r_rnd + 6'd1;
            end

            if (r_state == S_FOLD) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + w_work[i];
                end
            end

            if (w_emit) begin
                r_hash  <= C_H0;
                r_count <= '0;
                r_fin   <= 1'b0;
                r_done  <= 1'b0;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= w_digest;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    s256_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (w_sched_ctrl),
        .o_w    (w_w)
    );

    s256_round u_round (
        .i_clk  (i_clk),
        .i_ctrl (w_rnd_ctrl),
        .i_hash (r_hash),
        .i_w    (w_w),
        .o_work (w_work)
    );

endmodule

FILE: hdl/s256_chk.sv
`timescale 1ns / 1ps
module s256_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [7:0]   i_s_axis_tdata,
    input logic         i_s_axis_tuser,
    input logic         i_s_axis_tlast,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [255:0] o_m_axis_tdata
);

    // hold a digest until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("digest dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("digest changed while stalled");

    // a last request starts padding or a block's rounds, so input must stall next cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready)
        else $error("input still ready after a last request");

    // a digest is only produced while the input side is busy
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("digest appeared without finishing a message");

endmodule

bind sha256_message_hash s256_chk u_s256_chk (.*);

FILE: dv/tb_sha256_message_hash.sv
`timescale 1ns / 1ps
module tb_sha256_message_hash;

    localparam int          CLK_HI      = 6;
    localparam int          CLK_LO      = 6;
    localparam int          RESET_CYC   = 10;
    localparam int          TARGET_REQS = 1050;
    localparam int          TAIL_START  = 950;
    localparam int          LONG_HOLD   = 600;
    localparam int          DRAIN_CYC   = 200;
    localparam logic [7:0]  PAD_MARK    = 8'h80;
    localparam int          LEN_FIELD   = 56;
    localparam int          BLOCK_END   = 63;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam int EDGE_LEN [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    typedef struct {
        logic [7:0] data;
        logic       empty;
        logic       last;
        int         gap;
        bit         drain;
        bit         tail;
    } t_byte_req;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata = 8'h00;   // data_byte
    logic         i_s_axis_tuser = 1'b0;    // empty_req
    logic         i_s_axis_tlast = 1'b0;    // last
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [255:0] o_m_axis_tdata;           // digest_part0, part1, part2, part3

    t_byte_req    pend_q [$];
    t_byte_req    cur;
    bit           have_cur = 1'b0;
    int           gap_left = 0;
    logic [255:0] digest_q [$];
    int           err_cnt = 0;
    int           results_seen = 0;
    bit           s_fire = 1'b0;
    bit           in_tail = 1'b0;
    int           planned_reqs = 0;
    bit           drain_next = 1'b0;
    int           stall_left = 0;
    bit           long_hold_done = 1'b0;

    // Predictor state
    logic [31:0]  hash_st [8];
    logic [7:0]   blk_st [64];
    logic [60:0]  msg_len;

    sha256_message_hash u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #CLK_HI i_clk = 1'b1;
        #CLK_LO i_clk = 1'b0;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk_st[4*i], blk_st[4*i+1], blk_st[4*i+2], blk_st[4*i+3]};
        end
        for (i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
        e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
        for (i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + K_TABLE[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
        hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
    endtask

    task automatic restart_message();
        int i;
        for (i = 0; i < 8; i++) hash_st[i] = HASH_IV[i];
        for (i = 0; i < 64; i++) blk_st[i] = 8'h00;
        msg_len = '0;
    endtask

    // Fold one accepted request into the running hash; queue a digest on last
    task automatic absorb_request(input logic [7:0] data, input logic empty,
                                  input logic last);
        int           pos;
        int           i;
        logic [63:0]  bit_len;
        logic [255:0] dig;
        if (!empty) begin
            pos = int'(msg_len[5:0]);
            blk_st[pos] = data;
            msg_len = msg_len + 61'd1;
            if (pos == BLOCK_END) compress_block();
        end
        if (last) begin
            pos = int'(msg_len[5:0]);
            blk_st[pos] = PAD_MARK;
            for (i = pos + 1; i < 64; i++) blk_st[i] = 8'h00;
            // No room for the length field: spill into an extra block
            if (pos >= LEN_FIELD) begin
                compress_block();
                for (i = 0; i < 64; i++) blk_st[i] = 8'h00;
            end
            bit_len = {msg_len, 3'b000};
            for (i = 0; i < 8; i++) blk_st[LEN_FIELD + i] = bit_len[63 - 8*i -: 8];
            compress_block();
            for (i = 0; i < 4; i++) dig[64*i +: 64] = {hash_st[2*i], hash_st[2*i+1]};
            digest_q.insert(digest_q.size(), dig);
            restart_message();
        end
    endtask

    task automatic push_req(input logic [7:0] data, input logic empty, input logic last);
        t_byte_req r;
        bit        quiet;
        quiet   = (planned_reqs >= TAIL_START) || ((planned_reqs % 200) < 40);
        r.data  = data;
        r.empty = empty;
        r.last  = last;
        r.gap   = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        r.drain = drain_next;
        r.tail  = (planned_reqs >= TAIL_START);
        drain_next = 1'b0;
        pend_q.insert(pend_q.size(), r);
        if (!empty || last) planned_reqs++;
    endtask

    // Driver: present pending requests, change inputs on the falling edge
    always @(negedge i_clk) begin : driver
        logic nxt_valid;
        nxt_valid = 1'b0;
        if (i_rst_n) begin
            if (s_fire) have_cur = 1'b0;
            if (!have_cur && pend_q.size() != 0) begin
                cur = pend_q.pop_front();
                have_cur = 1'b1;
                gap_left = cur.gap;
            end
            if (have_cur) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!cur.drain || digest_q.size() == 0) begin
                    nxt_valid = 1'b1;
                end
            end
            if (have_cur) begin
                i_s_axis_tdata <= cur.data;
                i_s_axis_tuser <= cur.empty;
                i_s_axis_tlast <= cur.last;
                in_tail        <= cur.tail;
            end
            i_s_axis_tvalid <= nxt_valid;
        end
    end

    // Receiver: random stalls, one long hold-off, none near the end
    always @(negedge i_clk) begin : receiver
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            nxt_ready = 1'b1;
            if (stall_left > 0) begin
                stall_left--;
                nxt_ready = 1'b0;
            end else if (!long_hold_done && results_seen >= 3) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                nxt_ready = 1'b0;
            end else if (!in_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                nxt_ready = 1'b0;
            end
        end
        i_m_axis_tready <= nxt_ready;
    end

    always @(posedge i_clk) begin : monitor
        logic [255:0] want;
        int           p;
        if (i_rst_n) begin
            s_fire <= i_s_axis_tvalid && o_s_axis_tready;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (digest_q.size() == 0) begin
                    $error("unexpected digest %h", o_m_axis_tdata);
                    err_cnt++;
                end else begin
                    want = digest_q.pop_front();
                    for (p = 0; p < 4; p++) begin
                        if (o_m_axis_tdata[64*p +: 64] !== want[64*p +: 64]) begin
                            $error("digest_part%0d: expected %h, actual %h",
                                   p, want[64*p +: 64], o_m_axis_tdata[64*p +: 64]);
                            err_cnt++;
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                absorb_request(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            end
        end else begin
            s_fire <= 1'b0;
        end
    end

    initial begin
        int  len;
        int  msg_idx;
        int  i;
        int  r;
        bit  end_on_byte;

        restart_message();

        // Empty message, single extreme bytes, ignored empty, tail empty after bytes
        push_req(8'hff, 1'b1, 1'b1);
        push_req(8'h00, 1'b0, 1'b1);
        push_req(8'hff, 1'b0, 1'b1);
        push_req(8'h3c, 1'b1, 1'b0);
        push_req(8'h61, 1'b0, 1'b0);
        push_req(8'h62, 1'b0, 1'b0);
        push_req(8'h63, 1'b0, 1'b1);
        push_req(8'h5a, 1'b0, 1'b0);
        push_req(8'ha5, 1'b0, 1'b0);
        push_req(8'h00, 1'b1, 1'b1);
        push_req(8'hc3, 1'b1, 1'b0);
        push_req(8'h00, 1'b1, 1'b1);

        msg_idx = 0;
        while (planned_reqs < TARGET_REQS) begin
            msg_idx++;
            if (msg_idx == 8 || msg_idx == 25) drain_next = 1'b1;
            r = $urandom_range(0, 9);
            if (r < 3) len = EDGE_LEN[$urandom_range(0, 9)];
            else if (r == 3) len = 0;
            else len = $urandom_range(1, 70);
            end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 24) == 0) push_req(8'($urandom), 1'b1, 1'b0);
                push_req(8'($urandom), 1'b0, end_on_byte && (i == len - 1));
            end
            if (!end_on_byte) push_req(8'($urandom), 1'b1, 1'b1);
        end

        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || have_cur) @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/s256_pkg.sv
hdl/s256_sched.sv
hdl/s256_round.sv
hdl/sha256_message_hash.sv
hdl/s256_chk.sv
dv/tb_sha256_message_hash.sv
